/* design/bpa_pkg.sv */
// Shared constants, codes and state type for the buddy page allocator.
`default_nettype none
package bpa_pkg;

  localparam int FRAME_COUNT = 4096;
  localparam int ORDER_COUNT = 11;
  localparam int FRAME_W     = 12;
  localparam int LINK_W      = FRAME_W + 1;  // top bit marks a null link
  localparam int ORDER_W     = 4;
  localparam int TOTAL_W     = 13;

  localparam logic [LINK_W-1:0] NIL_LINK = {1'b1, {FRAME_W{1'b0}}};

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NO_MEM   = 2'd1,
    ST_REJECTED = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_AU_EX,
    S_SPLIT_CHK,
    S_SP_EX,
    S_SP_PUSH,
    S_SP_LINK,
    S_F_CHK,
    S_M_CHK,
    S_M_EX,
    S_F_PUSH,
    S_F_LINK,
    S_REPLY
  } state_e;

endpackage
`default_nettype wire

/* design/buddy_page_allocator.sv */
// Buddy page allocator: request sequencer, link memories and free lists.
//
// Usage: one request beat enters on the input channel (opcode, order, frame
// number); exactly one result beat (status, granted frame, free page total)
// leaves on the output channel. Both channels use valid/stall; a beat moves
// on a rising edge with valid high and stall low.
// Steps: an allocate scans the orders upward, then splits once per order
// down to the requested one; a free checks the frame, then merges with free
// buddies up to the top order; a request rejected at entry goes straight to
// reply. One request is in flight at a time and the next one enters from the
// idle state. Time is set by the single read port shared by the flag, order
// and link memories.
// Reset: lists empty, total zero. A clearing pass then zeroes the free flag
// of all 4096 frames, one frame a cycle, with input stalled.
// Output: the result sits in an output register; while the receiver stalls
// it holds, and a finished request waits in the reply state until the
// register drains. A new request may be accepted while a result still waits.
`default_nettype none
module buddy_page_allocator (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          opcode_i,
  input  wire logic [bpa_pkg::ORDER_W-1:0]   block_order_i,
  input  wire logic [bpa_pkg::FRAME_W-1:0]   frame_number_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [1:0]                         status_o,
  output logic [bpa_pkg::FRAME_W-1:0]        granted_frame_o,
  output logic [bpa_pkg::TOTAL_W-1:0]        pages_free_o
);

  localparam int FW = bpa_pkg::FRAME_W;
  localparam int LW = bpa_pkg::LINK_W;
  localparam int OW = bpa_pkg::ORDER_W;
  localparam int TW = bpa_pkg::TOTAL_W;
  localparam logic [OW-1:0] TOP_ORDER = OW'(bpa_pkg::ORDER_COUNT - 1);

  bpa_pkg::state_e state_q, state_d;

  // Per-frame memories
  logic          flag_mem [bpa_pkg::FRAME_COUNT];
  logic [OW-1:0] ord_mem  [bpa_pkg::FRAME_COUNT];
  logic [LW-1:0] next_mem [bpa_pkg::FRAME_COUNT];
  logic [LW-1:0] prev_mem [bpa_pkg::FRAME_COUNT];

  // Per-order list heads and tails
  logic [LW-1:0] first_q [bpa_pkg::ORDER_COUNT];
  logic [LW-1:0] last_q  [bpa_pkg::ORDER_COUNT];

  logic [FW-1:0] rd_addr;
  logic          rd_flag_q;
  logic [OW-1:0] rd_ord_q;
  logic [LW-1:0] rd_next_q, rd_prev_q;

  logic          fl_we, or_we, nx_we, pv_we, hd_we, tl_we;
  logic [FW-1:0] fl_wa, or_wa, nx_wa, pv_wa;
  logic          fl_wd;
  logic [OW-1:0] or_wd, hd_ix, tl_ix;
  logic [LW-1:0] nx_wd, pv_wd, hd_wd, tl_wd;

  logic          unl_en;
  logic [FW-1:0] unl_f;
  logic [OW-1:0] unl_o;

  logic [OW-1:0] c_q, c_d, ord_q, ord_d;
  logic [FW-1:0] pfn_q, pfn_d, bud_q, bud_d;
  logic [LW-1:0] lnk_q, lnk_d;
  logic [1:0]    res_st_q, res_st_d;
  logic [FW-1:0] res_gr_q, res_gr_d;
  logic [TW-1:0] total_q, total_d;
  logic [FW-1:0] clr_q;

  logic          out_valid_q;
  logic [1:0]    out_st_q;
  logic [FW-1:0] out_gr_q;
  logic [TW-1:0] out_pf_q;

  logic          in_acc, slot_free;
  logic [OW-1:0] c_dec;
  logic [TW-1:0] take_n;
  logic [TW:0]   give_sum;

  assign in_stall_o      = (state_q != bpa_pkg::S_IDLE);
  assign in_acc          = in_valid_i && !in_stall_o;
  assign slot_free       = !out_valid_q || !out_stall_i;
  assign out_valid_o     = out_valid_q;
  assign status_o        = out_st_q;
  assign granted_frame_o = out_gr_q;
  assign pages_free_o    = out_pf_q;
  assign c_dec           = c_q - OW'(1);
  assign take_n          = TW'(1) << ord_q;
  assign give_sum        = {1'b0, total_q} + {1'b0, take_n};

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bpa_pkg::S_CLEAR: begin
        if (clr_q == {FW{1'b1}}) state_d = bpa_pkg::S_IDLE;
      end
      bpa_pkg::S_IDLE: begin
        if (in_acc) begin
          if (32'(block_order_i) >= bpa_pkg::ORDER_COUNT) begin
            state_d = bpa_pkg::S_REPLY;
          end else if (opcode_i == bpa_pkg::OP_ALLOC) begin
            state_d = bpa_pkg::S_SCAN;
          end else if (frame_number_i == '0) begin
            state_d = bpa_pkg::S_REPLY;
          end else begin
            state_d = bpa_pkg::S_F_CHK;
          end
        end
      end
      bpa_pkg::S_SCAN: begin
        if (!first_q[c_q][LW-1])  state_d = bpa_pkg::S_AU_EX;
        else if (c_q == TOP_ORDER) state_d = bpa_pkg::S_REPLY;
      end
      bpa_pkg::S_AU_EX:     state_d = bpa_pkg::S_SPLIT_CHK;
      bpa_pkg::S_SPLIT_CHK: begin
        state_d = (c_q == ord_q) ? bpa_pkg::S_REPLY : bpa_pkg::S_SP_EX;
      end
      bpa_pkg::S_SP_EX:     state_d = bpa_pkg::S_SP_PUSH;
      bpa_pkg::S_SP_PUSH:   state_d = bpa_pkg::S_SP_LINK;
      bpa_pkg::S_SP_LINK:   state_d = bpa_pkg::S_SPLIT_CHK;
      bpa_pkg::S_F_CHK: begin
        state_d = rd_flag_q ? bpa_pkg::S_REPLY : bpa_pkg::S_M_CHK;
      end
      bpa_pkg::S_M_CHK: begin
        state_d = (c_q < TOP_ORDER) ? bpa_pkg::S_M_EX : bpa_pkg::S_F_PUSH;
      end
      bpa_pkg::S_M_EX: begin
        state_d = (rd_flag_q && rd_ord_q == c_q) ? bpa_pkg::S_M_CHK : bpa_pkg::S_F_PUSH;
      end
      bpa_pkg::S_F_PUSH:    state_d = bpa_pkg::S_F_LINK;
      bpa_pkg::S_F_LINK:    state_d = bpa_pkg::S_REPLY;
      bpa_pkg::S_REPLY: begin
        if (slot_free) state_d = bpa_pkg::S_IDLE;
      end
      default:              state_d = bpa_pkg::S_IDLE;
    endcase
  end

  // Datapath controls and memory writes
  always_comb begin
    c_d = c_q; ord_d = ord_q; pfn_d = pfn_q; bud_d = bud_q; lnk_d = lnk_q;
    res_st_d = res_st_q; res_gr_d = res_gr_q; total_d = total_q;
    rd_addr = pfn_q;
    fl_we = 1'b0; fl_wa = pfn_q; fl_wd = 1'b0;
    or_we = 1'b0; or_wa = pfn_q; or_wd = c_q;
    nx_we = 1'b0; nx_wa = pfn_q; nx_wd = bpa_pkg::NIL_LINK;
    pv_we = 1'b0; pv_wa = pfn_q; pv_wd = bpa_pkg::NIL_LINK;
    hd_we = 1'b0; hd_ix = c_q; hd_wd = bpa_pkg::NIL_LINK;
    tl_we = 1'b0; tl_ix = c_q; tl_wd = bpa_pkg::NIL_LINK;
    unl_en = 1'b0; unl_f = pfn_q; unl_o = c_q;
    case (state_q)
      bpa_pkg::S_CLEAR: begin
        fl_we = 1'b1; fl_wa = clr_q; fl_wd = 1'b0;
      end
      bpa_pkg::S_IDLE: begin
        rd_addr = frame_number_i;
        if (in_acc) begin
          c_d = block_order_i; ord_d = block_order_i; pfn_d = frame_number_i;
          res_st_d = bpa_pkg::ST_REJECTED; res_gr_d = '0;
        end
      end
      bpa_pkg::S_SCAN: begin
        rd_addr = first_q[c_q][FW-1:0];
        if (!first_q[c_q][LW-1]) begin
          pfn_d = first_q[c_q][FW-1:0];
        end else if (c_q == TOP_ORDER) begin
          res_st_d = bpa_pkg::ST_NO_MEM;
        end else begin
          c_d = c_q + OW'(1);
        end
      end
      bpa_pkg::S_AU_EX: begin
        unl_en = 1'b1; unl_f = pfn_q; unl_o = c_q;
      end
      bpa_pkg::S_SPLIT_CHK: begin
        // Peel off the upper half at the next lower order
        bud_d   = pfn_q ^ (FW'(1) << c_dec);
        rd_addr = bud_d;
        if (c_q == ord_q) begin
          total_d  = (total_q > take_n) ? total_q - take_n : '0;
          res_st_d = bpa_pkg::ST_DONE;
          res_gr_d = pfn_q;
        end else begin
          c_d = c_dec;
        end
      end
      bpa_pkg::S_SP_EX: begin
        unl_en = rd_flag_q; unl_f = bud_q; unl_o = rd_ord_q;
      end
      bpa_pkg::S_SP_PUSH: begin
        lnk_d = first_q[c_q];
        fl_we = 1'b1; fl_wa = bud_q; fl_wd = 1'b1;
        or_we = 1'b1; or_wa = bud_q; or_wd = c_q;
        nx_we = 1'b1; nx_wa = bud_q; nx_wd = first_q[c_q];
        pv_we = 1'b1; pv_wa = bud_q; pv_wd = bpa_pkg::NIL_LINK;
        hd_we = 1'b1; hd_wd = {1'b0, bud_q};
        tl_we = first_q[c_q][LW-1]; tl_wd = {1'b0, bud_q};
      end
      bpa_pkg::S_SP_LINK: begin
        pv_we = !lnk_q[LW-1]; pv_wa = lnk_q[FW-1:0]; pv_wd = {1'b0, bud_q};
      end
      bpa_pkg::S_F_CHK: begin
        if (!rd_flag_q) res_st_d = bpa_pkg::ST_DONE;
      end
      bpa_pkg::S_M_CHK: begin
        bud_d   = pfn_q ^ (FW'(1) << c_q);
        rd_addr = bud_d;
      end
      bpa_pkg::S_M_EX: begin
        // Merge only with a buddy free at this very order
        if (rd_flag_q && rd_ord_q == c_q) begin
          unl_en = 1'b1; unl_f = bud_q; unl_o = c_q;
          pfn_d = pfn_q & bud_q;
          c_d   = c_q + OW'(1);
        end
      end
      bpa_pkg::S_F_PUSH: begin
        lnk_d = last_q[c_q];
        fl_we = 1'b1; fl_wd = 1'b1;
        or_we = 1'b1; or_wd = c_q;
        nx_we = 1'b1; nx_wd = bpa_pkg::NIL_LINK;
        pv_we = 1'b1; pv_wd = last_q[c_q];
        tl_we = 1'b1; tl_wd = {1'b0, pfn_q};
        hd_we = last_q[c_q][LW-1]; hd_wd = {1'b0, pfn_q};
      end
      bpa_pkg::S_F_LINK: begin
        nx_we = !lnk_q[LW-1]; nx_wa = lnk_q[FW-1:0]; nx_wd = {1'b0, pfn_q};
        total_d = (give_sum > (TW+1)'(bpa_pkg::FRAME_COUNT)) ?
                  TW'(bpa_pkg::FRAME_COUNT) : give_sum[TW-1:0];
      end
      default: begin
      end
    endcase
    // Unlink a listed frame: bridge its neighbors, drop its flag
    if (unl_en) begin
      fl_we = 1'b1; fl_wa = unl_f; fl_wd = 1'b0;
      if (!rd_prev_q[LW-1]) begin
        nx_we = 1'b1; nx_wa = rd_prev_q[FW-1:0]; nx_wd = rd_next_q;
      end else begin
        hd_we = 1'b1; hd_ix = unl_o; hd_wd = rd_next_q;
      end
      if (!rd_next_q[LW-1]) begin
        pv_we = 1'b1; pv_wa = rd_next_q[FW-1:0]; pv_wd = rd_prev_q;
      end else begin
        tl_we = 1'b1; tl_ix = unl_o; tl_wd = rd_prev_q;
      end
    end
  end

  // Memories: one write per memory per cycle, shared registered read
  always_ff @(posedge clk_i) begin
    if (fl_we) flag_mem[fl_wa] <= fl_wd;
    if (or_we) ord_mem[or_wa]  <= or_wd;
    if (nx_we) next_mem[nx_wa] <= nx_wd;
    if (pv_we) prev_mem[pv_wa] <= pv_wd;
    rd_flag_q <= flag_mem[rd_addr];
    rd_ord_q  <= ord_mem[rd_addr];
    rd_next_q <= next_mem[rd_addr];
    rd_prev_q <= prev_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bpa_pkg::S_CLEAR;
      clr_q       <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < bpa_pkg::ORDER_COUNT; i++) begin
        first_q[i] <= bpa_pkg::NIL_LINK;
        last_q[i]  <= bpa_pkg::NIL_LINK;
      end
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      if (state_q == bpa_pkg::S_CLEAR) clr_q <= clr_q + FW'(1);
      if (hd_we) first_q[hd_ix] <= hd_wd;
      if (tl_we) last_q[tl_ix]  <= tl_wd;
      if (state_q == bpa_pkg::S_REPLY && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    c_q <= c_d; ord_q <= ord_d; pfn_q <= pfn_d; bud_q <= bud_d; lnk_q <= lnk_d;
    res_st_q <= res_st_d; res_gr_q <= res_gr_d;
    if (state_q == bpa_pkg::S_REPLY && slot_free) begin
      out_st_q <= res_st_q;
      out_gr_q <= res_gr_q;
      out_pf_q <= total_q;
    end
  end

  a_grant_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != bpa_pkg::ST_DONE |-> granted_frame_o == '0)
    else $error("granted frame set on a failed request");

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= TW'(bpa_pkg::FRAME_COUNT))
    else $error("free page total above frame count");

  a_result_from_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == bpa_pkg::S_REPLY))
    else $error("result beat raised outside reply");

  a_no_read_write_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bpa_pkg::S_SCAN || state_q == bpa_pkg::S_SPLIT_CHK ||
     state_q == bpa_pkg::S_M_CHK) |-> !(fl_we || nx_we || pv_we || or_we))
    else $error("memory write in a read issue cycle");

endmodule
`default_nettype wire
